// ===== sv/tsg_pkg.sv =====
// Package for the trapezoid step generator: field widths, opcodes, command kinds,
// register indexes, reset values and the structs passed between front, queue and back.
// No dependencies.
package tsg_pkg;

  // Field widths
  localparam int OPCODE_W  = 3;
  localparam int DIST_W    = 32;
  localparam int VEL_W     = 28;
  localparam int ACC_W     = 29;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 2;

  // Input opcodes as they arrive on tuser
  localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_MOVE_ABS = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MOVE_REL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_STOP     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_ENABLE   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DISABLE  = 3'd5;

  // Register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 2'd2;

  // Register reset values
  localparam logic [VEL_W-1:0] MAX_VEL_RST = 28'd16777216;
  localparam logic [VEL_W-1:0] MIN_VEL_RST = 28'd167772;
  localparam logic [VEL_W-1:0] ACCEL_RST   = 28'd16777;

  // Command kind after decode; unused opcodes become a no-op
  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_MOVE_ABS,
    KIND_MOVE_REL,
    KIND_HALT,
    KIND_ENABLE,
    KIND_DISABLE,
    KIND_NOP
  } cmd_kind_t;

  // One queued command
  typedef struct packed {
    cmd_kind_t          kind;
    logic [DIST_W-1:0]  distance;
  } cmd_t;

  // Result word, step_count in the lowest bits
  typedef struct packed {
    logic               enabled_out;
    logic               moving_out;
    logic [DIST_W-1:0]  position_out;
    logic               direction_out;
    logic [STEP_W-1:0]  step_count;
  } result_t;

  localparam int OUT_W = $bits(result_t);

endpackage

// ===== sv/tsg_front.sv =====
// Front end of the step generator: takes input transfers, decodes the opcode into a
// command kind and holds it in a one-entry slot. Uses tsg_pkg.
module tsg_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tsg_pkg::DIST_W-1:0]  s_tdata,   // [31:0] distance
  input  logic [tsg_pkg::OPCODE_W-1:0] s_tuser,  // [2:0] opcode
  output logic                        q_valid,
  input  logic                        q_ready,
  output tsg_pkg::cmd_t               q_cmd
);

  logic               slot_valid;
  tsg_pkg::cmd_t      slot_cmd;
  tsg_pkg::cmd_kind_t kind_dec;

  // Opcode decode
  always_comb begin
    unique case (s_tuser)
      tsg_pkg::OP_TICK:     kind_dec = tsg_pkg::KIND_TICK;
      tsg_pkg::OP_MOVE_ABS: kind_dec = tsg_pkg::KIND_MOVE_ABS;
      tsg_pkg::OP_MOVE_REL: kind_dec = tsg_pkg::KIND_MOVE_REL;
      tsg_pkg::OP_STOP:     kind_dec = tsg_pkg::KIND_HALT;
      tsg_pkg::OP_ENABLE:   kind_dec = tsg_pkg::KIND_ENABLE;
      tsg_pkg::OP_DISABLE:  kind_dec = tsg_pkg::KIND_DISABLE;
      default:              kind_dec = tsg_pkg::KIND_NOP;
    endcase
  end

  // Slot refills whenever it is empty or draining into the queue
  assign s_tready = !slot_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (s_tready) begin
      slot_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      slot_cmd.kind     <= kind_dec;
      slot_cmd.distance <= s_tdata;
    end
  end

  assign q_valid = slot_valid;
  assign q_cmd   = slot_cmd;

endmodule

// ===== sv/tsg_queue.sv =====
// Two-entry command queue between front and back, so that each side stalls on its own.
// Uses tsg_pkg.
module tsg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tsg_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output tsg_pkg::cmd_t out_cmd
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  tsg_pkg::cmd_t      entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != (PTR_W+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== sv/tsg_back.sv =====
// Back end of the step generator: holds the motion state and the velocity registers,
// executes one command per cycle (trapezoid profile on ticks) into an output register
// while that register is empty or m_tready is high. Uses tsg_pkg.
module tsg_back #(
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  tsg_pkg::cmd_t                 cmd,
  input  logic                          cfg_valid,
  input  logic [tsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsg_pkg::VEL_W-1:0]     cfg_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output tsg_pkg::result_t              m_result
);

  localparam int VW = tsg_pkg::VEL_W;
  localparam int AW = tsg_pkg::ACC_W;
  localparam int DW = tsg_pkg::DIST_W;

  // Velocity ceiling: 16 whole steps per tick less one LSB, within 28 bits
  localparam longint unsigned CAP_RAW  = (64'd16 << FRAC_BITS) - 64'd1;
  localparam logic [VW-1:0]   VEL_CAP  = (CAP_RAW > 64'h0FFF_FFFF) ? 28'h0FFF_FFFF
                                                                   : VW'(CAP_RAW);
  localparam logic [AW:0]     FRAC_MSK = (AW+1)'((64'd1 << FRAC_BITS) - 64'd1);

  // Configuration registers
  logic [VW-1:0] max_velocity;
  logic [VW-1:0] vel_floor;
  logic [VW-1:0] accel_step;

  // Motion state
  logic [DW-1:0] position, position_next;
  logic [DW-1:0] target, target_next;
  logic [VW-1:0] velocity, velocity_next;
  logic [AW-1:0] accumulator, accumulator_next;
  logic          direction, direction_next;
  logic          moving, moving_next;
  logic          enabled, enabled_next;
  logic [tsg_pkg::STEP_W-1:0] steps;

  // Tick datapath
  logic [DW-1:0]         diff;
  logic                  want;
  logic [DW-1:0]         remain;
  logic [VW+DW-1:0]      accel_dist;
  logic [2*VW-1:0]       vel_sq;
  logic [2*VW-1:0]       vel_sq_sh;
  logic                  brake;
  logic signed [VW+1:0]  vel_dec;
  logic                  dec_low;
  logic [VW:0]           vel_inc;
  logic                  inc_high;
  logic                  reverse;
  logic [VW-1:0]         vel_sel;
  logic [VW-1:0]         vel_cap;
  logic                  tick_dir;
  logic [AW:0]           acc_sum;
  logic [AW:0]           whole;
  logic [DW-1:0]         reach;
  logic                  arrive;
  logic [DW-1:0]         move_tgt;
  logic                  take;

  assign cmd_ready = !m_tvalid || m_tready;
  assign take      = cmd_valid && cmd_ready;

  // Remaining distance and braking test: 2*accel*remain <= v*v >> FRAC_BITS
  assign diff       = target - position;
  assign want       = ~diff[DW-1];
  assign remain     = want ? diff : (DW'(0) - diff);
  assign accel_dist = {{DW{1'b0}}, accel_step} * {{VW{1'b0}}, remain};
  assign vel_sq     = {{VW{1'b0}}, velocity} * {{VW{1'b0}}, velocity};
  assign vel_sq_sh  = vel_sq >> FRAC_BITS;
  assign brake      = {accel_dist, 1'b0} <= {{(DW-VW+1){1'b0}}, vel_sq_sh};

  // Candidate velocities
  assign vel_dec  = $signed({2'b00, velocity}) - $signed({2'b00, accel_step});
  assign dec_low  = vel_dec < $signed({2'b00, vel_floor});
  assign vel_inc  = {1'b0, velocity} + {1'b0, accel_step};
  assign inc_high = vel_inc > {1'b0, max_velocity};
  assign reverse  = (want != direction) && (velocity > vel_floor);

  // Profile rule: reversal brake, then braking distance, then acceleration
  always_comb begin
    if (reverse) begin
      vel_sel  = dec_low ? vel_floor : vel_dec[VW-1:0];
      tick_dir = dec_low ? want : direction;
    end else if (brake) begin
      vel_sel  = dec_low ? vel_floor : vel_dec[VW-1:0];
      tick_dir = want;
    end else begin
      vel_sel  = inc_high ? max_velocity : vel_inc[VW-1:0];
      tick_dir = want;
    end
  end

  // Step accumulation and arrival check
  assign vel_cap = (vel_sel > VEL_CAP) ? VEL_CAP : vel_sel;
  assign acc_sum = {1'b0, accumulator} + {2'b00, vel_cap};
  assign whole   = acc_sum >> FRAC_BITS;
  assign reach   = tick_dir ? (target - position) : (position - target);
  assign arrive  = {{(DW-AW-1){1'b0}}, whole} >= reach;

  assign move_tgt = (cmd.kind == tsg_pkg::KIND_MOVE_REL) ? (position + cmd.distance)
                                                         : cmd.distance;

  // Command execution
  always_comb begin
    position_next    = position;
    target_next      = target;
    velocity_next    = velocity;
    accumulator_next = accumulator;
    direction_next   = direction;
    moving_next      = moving;
    enabled_next     = enabled;
    steps            = '0;
    unique case (cmd.kind) inside
      tsg_pkg::KIND_TICK: begin
        if (moving && enabled) begin
          if (remain == '0) begin
            moving_next      = 1'b0;
            velocity_next    = '0;
            accumulator_next = '0;
          end else begin
            direction_next = tick_dir;
            if (arrive) begin
              position_next    = target;
              moving_next      = 1'b0;
              velocity_next    = '0;
              accumulator_next = '0;
              steps            = reach[tsg_pkg::STEP_W-1:0];
            end else begin
              position_next    = tick_dir ? position + {{(DW-AW-1){1'b0}}, whole}
                                          : position - {{(DW-AW-1){1'b0}}, whole};
              velocity_next    = vel_cap;
              accumulator_next = AW'(acc_sum & FRAC_MSK);
              steps            = whole[tsg_pkg::STEP_W-1:0];
            end
          end
        end
      end
      tsg_pkg::KIND_MOVE_ABS, tsg_pkg::KIND_MOVE_REL: begin
        if (!(move_tgt == position && !moving)) begin
          target_next = move_tgt;
          moving_next = 1'b1;
        end
      end
      tsg_pkg::KIND_HALT, tsg_pkg::KIND_DISABLE: begin
        target_next      = position;
        velocity_next    = '0;
        accumulator_next = '0;
        moving_next      = 1'b0;
        if (cmd.kind == tsg_pkg::KIND_DISABLE) enabled_next = 1'b0;
      end
      tsg_pkg::KIND_ENABLE: begin
        enabled_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers; the user must write them only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity <= tsg_pkg::MAX_VEL_RST;
      vel_floor    <= tsg_pkg::MIN_VEL_RST;
      accel_step   <= tsg_pkg::ACCEL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsg_pkg::CFG_MAX_VEL: max_velocity <= cfg_data;
        tsg_pkg::CFG_MIN_VEL: vel_floor    <= cfg_data;
        tsg_pkg::CFG_ACCEL:   accel_step   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      target      <= '0;
      velocity    <= '0;
      accumulator <= '0;
      direction   <= 1'b1;
      moving      <= 1'b0;
      enabled     <= 1'b0;
    end else if (take) begin
      position    <= position_next;
      target      <= target_next;
      velocity    <= velocity_next;
      accumulator <= accumulator_next;
      direction   <= direction_next;
      moving      <= moving_next;
      enabled     <= enabled_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd_ready) begin
      m_tvalid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_result.step_count    <= steps;
      m_result.direction_out <= direction_next;
      m_result.position_out  <= position_next;
      m_result.moving_out    <= moving_next;
      m_result.enabled_out   <= enabled_next;
    end
  end

endmodule

// ===== sv/trapezoid_step_generator.sv =====
// Top level of the trapezoid step generator: front decode, command queue, back end.
// Uses tsg_pkg, tsg_front, tsg_queue, tsg_back.
//
//   channel  | direction | tdata / data             | tuser / index
//   ---------+-----------+--------------------------+---------------
//   s_axis   | in        | [31:0] distance          | [2:0] opcode
//   m_axis   | out       | [4:0] step_count, [5] direction_out, [37:6] position_out,
//            |           | [38] moving_out, [39] enabled_out
//   cfg      | in        | cfg_data [27:0]          | cfg_index [1:0]
//
// One command per cycle sustained while m_tready stays high; m_tvalid rises after the input
// transfer has passed the input slot, the queue and the output register, in that order.
// The rate is set by the back end, whose motion state feeds the next command's profile step.
// Synchronous reset clears valid flags, queue pointers and motion state and restores the
// register reset values; slot and queue contents and the result word are not reset.
// A stalled m_tready fills the output register, queue and input slot before
// s_tready drops; config writes are taken every cycle (cfg_ready is tied high).
module trapezoid_step_generator #(
  parameter int FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tsg_pkg::DIST_W-1:0]     s_tdata,   // [31:0] distance
  input  logic [tsg_pkg::OPCODE_W-1:0]   s_tuser,   // [2:0] opcode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tsg_pkg::OUT_W-1:0]      m_tdata,   // [4:0] step_count, [5] direction_out,
                                                    // [37:6] position_out, [38] moving_out,
                                                    // [39] enabled_out
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsg_pkg::VEL_W-1:0]      cfg_data
);

  logic             fq_valid;
  logic             fq_ready;
  tsg_pkg::cmd_t    fq_cmd;
  logic             qb_valid;
  logic             qb_ready;
  tsg_pkg::cmd_t    qb_cmd;
  tsg_pkg::result_t result;

  assign cfg_ready = 1'b1;
  assign m_tdata   = result;

  tsg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_cmd    (fq_cmd)
  );

  tsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_cmd   (qb_cmd)
  );

  tsg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_result  (result)
  );

endmodule

// ===== sv/tsg_checker.sv =====
// Port-level checks for the trapezoid step generator, bound to the top level.
// Uses tsg_pkg for widths.
module tsg_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [tsg_pkg::OUT_W-1:0] m_tdata
);

  // No result is presented right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Velocity cap keeps a tick at 16 steps or fewer
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:0] <= 5'd16))
    else $error("step_count above 16");

  // Steps are only issued while the driver is enabled
  a_step_enabled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:0] != 5'd0) |-> m_tdata[39])
    else $error("steps issued while disabled");

endmodule

bind trapezoid_step_generator tsg_checker u_tsg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/testbench.sv =====
// Self-checking bench for trapezoid_step_generator: directed commands, register extremes,
// backpressure and long random motion runs against a cycle-free motion predictor.
// Depends on tsg_pkg and the trapezoid_step_generator RTL.
module testbench;
  import tsg_pkg::*;

  localparam int FRAC_BITS = 24;
  localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [VEL_W-1:0] VEL_FULL = 28'hFFF_FFFF;
  localparam longint VEL_CEIL_RAW = (64'd16 << FRAC_BITS) - 1;
  localparam longint VEL_CEIL = (VEL_CEIL_RAW > 64'hFFF_FFFF) ? 64'hFFF_FFFF : VEL_CEIL_RAW;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // Block ports, all driven from time zero
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DIST_W-1:0]    s_tdata = '0;    // [31:0] distance
  logic [OPCODE_W-1:0]  s_tuser = '0;    // [2:0] opcode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;         // [4:0] step_count, [5] direction_out,
                                         // [37:6] position_out, [38] moving_out,
                                         // [39] enabled_out
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VEL_W-1:0]     cfg_data = '0;

  trapezoid_step_generator #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Predicted motor state and profile registers
  logic [31:0]      motor_pos, motor_target;
  logic [VEL_W-1:0] motor_vel;
  logic [ACC_W-1:0] motor_frac;
  logic             motor_dir, motor_moving, motor_enabled;
  logic [VEL_W-1:0] lim_max_vel, lim_min_vel, ramp_accel;

  // Expected status words, oldest first
  result_t expected_status_q[$];

  // Run bookkeeping
  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  int unsigned tick_count = 0;
  int unsigned checked_count = 0;
  int unsigned cfg_count = 0;
  longint unsigned step_total = 0;
  int unsigned quiet_cycles = 0;

  // Idle control shared with the result sink
  bit sender_steady = 1'b0;
  bit sink_steady = 1'b0;
  int unsigned hold_req = 0;

  // ---------------------------------------------------------------- predictor

  function automatic void motor_halt();
    motor_target = motor_pos;
    motor_vel = '0;
    motor_frac = '0;
    motor_moving = 1'b0;
  endfunction

  function automatic void motor_move_to(logic [31:0] goal);
    if (goal == motor_pos && !motor_moving) return;
    motor_target = goal;
    motor_moving = 1'b1;
  endfunction

  // One profile step; returns the whole steps issued
  function automatic logic [31:0] motor_tick();
    logic [31:0] diff, remain, reach;
    logic        want;
    logic [63:0] brake_lhs, brake_rhs, acc, whole;
    longint      v, a_s, lo_s, hi_s;
    if (!motor_moving || !motor_enabled) return 32'd0;
    diff = motor_target - motor_pos;
    want = ~diff[31];
    remain = want ? diff : -diff;
    if (remain == 0) begin
      motor_moving = 1'b0;
      motor_vel = '0;
      motor_frac = '0;
      return 32'd0;
    end
    brake_lhs = 64'(ramp_accel) * 64'(remain) * 64'd2;
    brake_rhs = (64'(motor_vel) * 64'(motor_vel)) >> FRAC_BITS;
    v = motor_vel;
    a_s = ramp_accel;
    lo_s = lim_min_vel;
    hi_s = lim_max_vel;
    // reversal brakes first, then the braking-distance test, else ramp up
    if (want != motor_dir && motor_vel > lim_min_vel) begin
      v = v - a_s;
      if (v < lo_s) begin
        v = lo_s;
        motor_dir = want;
      end
    end else if (brake_lhs <= brake_rhs) begin
      motor_dir = want;
      v = v - a_s;
      if (v < lo_s) v = lo_s;
    end else begin
      motor_dir = want;
      v = v + a_s;
      if (v > hi_s) v = hi_s;
    end
    if (v < 0) v = 0;
    if (v > VEL_CEIL) v = VEL_CEIL;
    motor_vel = VEL_W'(v);

    // integrate; clip at the target
    acc = 64'(motor_frac) + 64'(motor_vel);
    whole = acc >> FRAC_BITS;
    reach = motor_dir ? motor_target - motor_pos : motor_pos - motor_target;
    if (whole >= 64'(reach)) begin
      motor_pos = motor_target;
      motor_moving = 1'b0;
      motor_vel = '0;
      motor_frac = '0;
      return reach;
    end
    motor_pos = motor_dir ? motor_pos + whole[31:0] : motor_pos - whole[31:0];
    motor_frac = ACC_W'(acc - (whole << FRAC_BITS));
    return whole[31:0];
  endfunction

  function automatic result_t advance_motor(logic [OPCODE_W-1:0] op, logic [31:0] cmd_arg);
    result_t     r;
    logic [31:0] steps;
    steps = 32'd0;
    case (op)
      OP_TICK:     steps = motor_tick();
      OP_MOVE_ABS: motor_move_to(cmd_arg);
      OP_MOVE_REL: motor_move_to(motor_pos + cmd_arg);
      OP_STOP:     motor_halt();
      OP_ENABLE:   motor_enabled = 1'b1;
      OP_DISABLE: begin
        motor_halt();
        motor_enabled = 1'b0;
      end
      default: ;
    endcase
    step_total += steps;
    r.step_count = steps[STEP_W-1:0];
    r.direction_out = motor_dir;
    r.position_out = motor_pos;
    r.moving_out = motor_moving;
    r.enabled_out = motor_enabled;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Mostly back to back, sometimes a few cycles, rarely a long gap
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] small_offset();
    return 32'($urandom_range(0, 600)) - 32'd300;
  endfunction

  // One command transfer; prediction is taken at the accepting edge
  task automatic send_cmd(logic [OPCODE_W-1:0] op, logic [31:0] cmd_arg);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= cmd_arg;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    expected_status_q.push_back(advance_motor(op, cmd_arg));
    sent_count++;
    if (op == OP_TICK) tick_count++;
    gap = pick_gap(sender_steady);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every expected result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_status_q.size() != 0);
  endtask

  // Leaves cfg_valid high; the caller lowers it
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [VEL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_VEL: lim_max_vel = value;
      CFG_MIN_VEL: lim_min_vel = value;
      CFG_ACCEL:   ramp_accel = value;
      default: ;
    endcase
    cfg_count++;
  endtask

  task automatic set_profile(logic [VEL_W-1:0] vmax, logic [VEL_W-1:0] vmin,
                             logic [VEL_W-1:0] accel);
    wait_drained();
    cfg_write(CFG_MAX_VEL, vmax);
    cfg_write(CFG_MIN_VEL, vmin);
    cfg_write(CFG_ACCEL, accel);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_random_profile();
    logic [VEL_W-1:0] vmax, vmin, accel;
    accel = VEL_W'($urandom_range(1 << 17, 1 << 25));
    vmax = VEL_W'($urandom_range(1 << 22, 1 << 27));
    vmin = VEL_W'($urandom_range(0, 1 << 23));
    if ($urandom_range(0, 7) == 0) vmax = VEL_W'($urandom());
    if ($urandom_range(0, 7) == 0) vmin = VEL_W'($urandom());
    set_profile(vmax, vmin, accel);
  endtask

  // ---------------------------------------------------------------- result side

  // Ready pattern: random stalls, quiet stretches, and requested long holds
  initial begin : result_sink
    int unsigned n;
    forever begin
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = pick_gap(sink_steady);
      end
      if (n != 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, seen);
      mismatches++;
    end
  endfunction

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t seen, want;
    if (!rst && m_tvalid && m_tready) begin
      seen = result_t'(m_tdata);
      if (expected_status_q.size() == 0) begin
        $error("result transfer with no command outstanding: %0h", m_tdata);
        mismatches++;
      end else begin
        want = expected_status_q.pop_front();
        check_field("step_count", 32'(want.step_count), 32'(seen.step_count));
        check_field("direction_out", 32'(want.direction_out), 32'(seen.direction_out));
        check_field("position_out", want.position_out, seen.position_out);
        check_field("moving_out", 32'(want.moving_out), 32'(seen.moving_out));
        check_field("enabled_out", 32'(want.enabled_out), 32'(seen.enabled_out));
        checked_count++;
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles, %0d results outstanding",
             quiet_cycles, expected_status_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Idle tick and the unused opcodes right after reset
  task automatic test_reset_state();
    send_cmd(OP_TICK, 32'hFFFF_FFFF);
    send_cmd(OP_SPARE_A, 32'h1234_5678);
    send_cmd(OP_SPARE_B, 32'h8765_4321);
  endtask

  // A move is armed while disabled, but ticks do nothing until enable
  task automatic test_disabled_commands();
    send_cmd(OP_MOVE_ABS, 32'd5);
    send_cmd(OP_TICK, 32'd0);
    send_cmd(OP_ENABLE, 32'd0);
  endtask

  task automatic test_short_move();
    int unsigned n;
    set_profile(VEL_W'(2 << FRAC_BITS), VEL_W'(1 << 22), VEL_W'(1 << 23));
    n = 0;
    while (motor_moving && n < 4) begin
      send_cmd(OP_TICK, 32'd0);
      n++;
    end
  endtask

  // Retarget to the current position mid move; the next tick ends it
  task automatic test_tick_at_target();
    send_cmd(OP_MOVE_REL, 32'd30);
    send_cmd(OP_TICK, 32'd0);
    send_cmd(OP_MOVE_ABS, motor_pos);
    send_cmd(OP_TICK, 32'd0);
  endtask

  // Reverse while moving: brake to the floor, then turn around
  task automatic test_reversal();
    int unsigned n;
    send_cmd(OP_MOVE_REL, 32'd40);
    send_cmd(OP_TICK, 32'd0);
    send_cmd(OP_TICK, 32'd0);
    send_cmd(OP_MOVE_REL, -32'd80);
    for (n = 0; n < 3; n++) send_cmd(OP_TICK, 32'd0);
    send_cmd(OP_STOP, 32'd0);
  endtask

  // Half-range difference, top of range target, disable, no-op move
  task automatic test_extreme_distances();
    send_cmd(OP_MOVE_REL, 32'h8000_0000);
    send_cmd(OP_TICK, 32'h8000_0000);
    send_cmd(OP_MOVE_ABS, 32'h7FFF_FFFF);
    send_cmd(OP_TICK, 32'hFFFF_FFFF);
    send_cmd(OP_DISABLE, 32'd0);
    send_cmd(OP_MOVE_ABS, motor_pos);
  endtask

  // Moves with random content, mostly ticks, some stray commands
  task automatic random_motion(int unsigned n_items, bit vary_profile);
    int unsigned first, ticks, r;
    first = sent_count;
    while (sent_count - first < n_items) begin
      if (vary_profile && $urandom_range(0, 5) == 0) set_random_profile();
      sender_steady = ($urandom_range(0, 6) == 0);
      sink_steady = ($urandom_range(0, 6) == 0);
      if (!motor_enabled) send_cmd(OP_ENABLE, $urandom());
      r = $urandom_range(0, 19);
      if (r < 12) send_cmd(OP_MOVE_REL, small_offset());
      else if (r < 16) send_cmd(OP_MOVE_ABS, motor_pos + small_offset());
      else if (r < 17) send_cmd(OP_MOVE_ABS, motor_pos);
      else if (r < 18) send_cmd(OP_MOVE_REL, 32'd0);
      else send_cmd(OP_MOVE_ABS, $urandom());
      ticks = $urandom_range(4, 90);
      while (motor_moving && ticks != 0) begin
        ticks--;
        if ($urandom_range(0, 99) < 5)
          send_cmd(OPCODE_W'($urandom_range(0, 7)),
                   ($urandom_range(0, 2) == 0) ? 32'($urandom()) : small_offset());
        else
          send_cmd(OP_TICK, $urandom());
      end
      if ($urandom_range(0, 3) == 0)
        send_cmd($urandom_range(0, 1) ? OP_STOP : OP_DISABLE, $urandom());
    end
    sender_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Out-of-range index, then corner profiles
  task automatic test_profile_extremes();
    wait_drained();
    cfg_write(CFG_SPARE, VEL_W'($urandom()));
    cfg_valid <= 1'b0;
    @(posedge clk);
    random_motion(40, 1'b0);
    set_profile(VEL_FULL, 28'd0, VEL_FULL);
    random_motion(60, 1'b0);
    set_profile(28'd0, 28'd0, 28'd1);
    random_motion(40, 1'b0);
    set_profile(VEL_FULL, VEL_FULL, 28'd1);
    random_motion(60, 1'b0);
    // zero ramp: settles at the floor
    set_profile(VEL_W'(1 << 25), VEL_W'(1 << 23), 28'd0);
    random_motion(50, 1'b0);
    // floor above ceiling
    set_profile(VEL_W'(1 << 22), VEL_W'(3 << 24), VEL_W'(1 << 20));
    random_motion(50, 1'b0);
    set_profile(MAX_VEL_RST, MIN_VEL_RST, ACCEL_RST);
    random_motion(30, 1'b0);
  endtask

  // Long receiver hold with the sender streaming, then a full drain
  task automatic test_backpressure();
    int unsigned n;
    set_profile(VEL_W'(3 << 24), VEL_W'(1 << 22), VEL_W'(1 << 22));
    sender_steady = 1'b1;
    hold_req = 150;
    send_cmd(OP_ENABLE, 32'd0);
    send_cmd(OP_MOVE_REL, 32'd400);
    for (n = 0; n < 40; n++) send_cmd(OP_TICK, $urandom());
    sender_steady = 1'b0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    lim_max_vel = MAX_VEL_RST;
    lim_min_vel = MIN_VEL_RST;
    ramp_accel = ACCEL_RST;
    motor_pos = '0;
    motor_target = '0;
    motor_vel = '0;
    motor_frac = '0;
    motor_dir = 1'b1;
    motor_moving = 1'b0;
    motor_enabled = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_disabled_commands();
    test_short_move();
    test_tick_at_target();
    test_reversal();
    test_extreme_distances();
    test_profile_extremes();
    test_backpressure();
    random_motion(1000, 1'b1);

    // drain, then make sure nothing extra shows up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d commands (%0d ticks, %0d steps) over %0d register writes",
             sent_count, tick_count, step_total, cfg_count);
    $display("checked %0d results, %0d mismatches", checked_count, mismatches);
    if (mismatches == 0 && expected_status_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
